@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assertion failed");
`define ASSERT_ANY(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ANY(lbl, clk, prop)
`endif

`endif

@@ src/drpb_pkg.sv @@
package drpb_pkg;

  localparam int COARSE_DEPTH = 2048;
  localparam int FINE_DEPTH   = 4096;
  localparam int CLR_DEPTH    = (COARSE_DEPTH > FINE_DEPTH) ? COARSE_DEPTH : FINE_DEPTH;

  localparam int CAW     = $clog2(COARSE_DEPTH);
  localparam int FAW     = $clog2(FINE_DEPTH);
  localparam int BANK_AW = $clog2(CLR_DEPTH);

  localparam int POS_W    = 32;
  localparam int ZH_W     = 31;
  localparam int INV_W    = 24;
  localparam int FRAC_W   = 24;
  localparam int CU_W     = 12;
  localparam int FU_W     = 13;
  localparam int FRAME_W  = 32;
  localparam int STRESS_W = 32;
  localparam int TRACE_W  = STRESS_W + 2;
  localparam int RIDX_W   = 12;
  localparam int CNT_W    = 32;
  localparam int SUM_W    = 48;
  localparam int PROD_W   = POS_W + INV_W;
  localparam int RAW_W    = PROD_W - FRAC_W;
  localparam int ENTRY_W  = CNT_W + SUM_W;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int OUT_DEPTH = 8;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_PARTICLE  = 2'd0,
    KIND_FRAME     = 2'd1,
    KIND_RD_COARSE = 2'd2,
    KIND_RD_FINE   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_LOW       = 3'd0,
    CFG_X_HIGH      = 3'd1,
    CFG_Z_HIGH      = 3'd2,
    CFG_COARSE_INV  = 3'd3,
    CFG_FINE_INV    = 3'd4,
    CFG_COARSE_USED = 3'd5,
    CFG_FINE_USED   = 3'd6,
    CFG_WARMUP      = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x_low;
    logic signed [POS_W-1:0] x_high;
    logic [ZH_W-1:0]         z_high;
    logic [INV_W-1:0]        coarse_inv;
    logic [INV_W-1:0]        fine_inv;
    logic [CU_W-1:0]         coarse_used;
    logic [FU_W-1:0]         fine_used;
    logic [FRAME_W-1:0]      warmup;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]        cnt;
    logic signed [SUM_W-1:0] sum;
  } entry_t;

  typedef struct packed {
    logic                      valid;
    kind_t                     kind;
    logic                      bin;
    logic [POS_W-1:0]          offset;
    logic signed [TRACE_W-1:0] trace;
    logic [RIDX_W-1:0]         read_index;
    logic [FRAME_W-1:0]        frames;
  } front_t;

  typedef struct packed {
    logic                      valid;
    kind_t                     kind;
    logic                      bin;
    logic [PROD_W-1:0]         prod_c;
    logic [PROD_W-1:0]         prod_f;
    logic signed [TRACE_W-1:0] trace;
    logic [RIDX_W-1:0]         read_index;
    logic [FRAME_W-1:0]        frames;
  } mult_t;

  typedef struct packed {
    logic                      valid;
    kind_t                     kind;
    logic                      bin;
    logic [CAW-1:0]            addr_c;
    logic [FAW-1:0]            addr_f;
    logic                      c_ok;
    logic                      f_ok;
    logic signed [TRACE_W-1:0] trace;
    logic [FRAME_W-1:0]        frames;
  } rmw_t;

  typedef struct packed {
    logic                    accepted;
    logic [CAW-1:0]          coarse_hit;
    logic [FAW-1:0]          fine_hit;
    logic [CNT_W-1:0]        bin_count;
    logic signed [SUM_W-1:0] bin_stress;
    logic [FRAME_W-1:0]      frames_averaged;
  } result_t;

endpackage

@@ src/drpb_ram.sv @@
module drpb_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 80
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/drpb_front.sv @@
module drpb_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  drpb_pkg::cfg_t                         cfg,
  input  logic                                   in_fire,
  input  logic [1:0]                             in_kind,
  input  logic signed [drpb_pkg::POS_W-1:0]      in_x_pos,
  input  logic signed [drpb_pkg::POS_W-1:0]      in_z_pos,
  input  logic signed [drpb_pkg::STRESS_W-1:0]   in_stress_xx,
  input  logic signed [drpb_pkg::STRESS_W-1:0]   in_stress_yy,
  input  logic signed [drpb_pkg::STRESS_W-1:0]   in_stress_zz,
  input  logic [drpb_pkg::RIDX_W-1:0]            in_read_index,
  output drpb_pkg::front_t                       s1_r
);
  import drpb_pkg::*;

  logic [FRAME_W-1:0]        frame_number_r, frame_number_nxt;
  logic [FRAME_W-1:0]        frames_kept_r, frames_kept_nxt;
  logic                      warm;
  logic                      in_win;
  logic [POS_W:0]            diff;
  logic signed [TRACE_W-1:0] trace;
  kind_t                     kind;
  front_t                    s1_nxt;

  assign kind = kind_t'(in_kind);
  assign warm = frame_number_r >= cfg.warmup;
  assign in_win = (in_x_pos >= cfg.x_low) && (in_x_pos <= cfg.x_high) &&
                  !in_z_pos[POS_W-1] && (in_z_pos[ZH_W-1:0] <= cfg.z_high);
  assign diff = {in_x_pos[POS_W-1], in_x_pos} - {cfg.x_low[POS_W-1], cfg.x_low};
  assign trace = {{2{in_stress_xx[STRESS_W-1]}}, in_stress_xx} +
                 {{2{in_stress_yy[STRESS_W-1]}}, in_stress_yy} +
                 {{2{in_stress_zz[STRESS_W-1]}}, in_stress_zz};

  always_comb begin
    frame_number_nxt = frame_number_r;
    frames_kept_nxt  = frames_kept_r;
    if (in_fire && kind == KIND_FRAME) begin
      if (warm && frames_kept_r != '1) begin
        frames_kept_nxt = frames_kept_r + 1'b1;
      end
      if (frame_number_r != '1) begin
        frame_number_nxt = frame_number_r + 1'b1;
      end
    end
    s1_nxt.valid      = in_fire;
    s1_nxt.kind       = kind;
    s1_nxt.bin        = (kind == KIND_PARTICLE) && warm && in_win;
    s1_nxt.offset     = diff[POS_W-1:0];
    s1_nxt.trace      = trace;
    s1_nxt.read_index = in_read_index;
    s1_nxt.frames     = frames_kept_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_number_r <= '0;
      frames_kept_r  <= '0;
      s1_r           <= '0;
    end else begin
      frame_number_r <= frame_number_nxt;
      frames_kept_r  <= frames_kept_nxt;
      s1_r           <= s1_nxt;
    end
  end

endmodule

@@ src/drpb_accum.sv @@
`include "assert_macros.svh"

module drpb_accum (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 upd,
  input  logic [drpb_pkg::BANK_AW-1:0]         addr,
  input  logic signed [drpb_pkg::TRACE_W-1:0]  trace,
  input  drpb_pkg::entry_t                     rdata,
  output drpb_pkg::entry_t                     cur,
  output logic                                 we,
  output drpb_pkg::entry_t                     wdata
);
  import drpb_pkg::*;

  logic                fwd_valid_r;
  logic [BANK_AW-1:0]  fwd_addr_r;
  entry_t              fwd_data_r;
  logic signed [SUM_W:0] sum_wide;

  // newest value of the bin: last beat's write has not reached the read data yet
  assign cur = (fwd_valid_r && fwd_addr_r == addr) ? fwd_data_r : rdata;

  assign sum_wide = {cur.sum[SUM_W-1], cur.sum} +
                    {{(SUM_W + 1 - TRACE_W){trace[TRACE_W-1]}}, trace};

  always_comb begin
    wdata.cnt = (cur.cnt == '1) ? cur.cnt : cur.cnt + 1'b1;
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      wdata.sum = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      wdata.sum = sum_wide[SUM_W-1:0];
    end
  end

  assign we = upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else begin
      fwd_valid_r <= upd;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= addr;
    fwd_data_r <= wdata;
  end

  `ASSERT_RST(a_fwd_same_bin, clk, rst_n, upd && $past(upd) && addr == $past(addr) |-> cur == $past(wdata))
  `ASSERT_RST(a_cnt_nonzero, clk, rst_n, upd |-> wdata.cnt != '0)
  `ASSERT_RST(a_sum_direction, clk, rst_n, upd && trace >= 0 |-> wdata.sum >= cur.sum)

endmodule

@@ src/drpb_out_fifo.sv @@
`include "assert_macros.svh"

module drpb_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  drpb_pkg::result_t push_data,
  input  logic              pop,
  output logic              out_valid,
  output drpb_pkg::result_t head
);
  import drpb_pkg::*;

  result_t            mem_r [OUT_DEPTH];
  logic [OUT_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [OUT_CW-1:0]  cnt_r, cnt_nxt;

  assign out_valid = cnt_r != '0;
  assign head = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `ASSERT_RST(a_no_overflow, clk, rst_n, !(push && !pop && cnt_r == OUT_CW'(OUT_DEPTH)))
  `ASSERT_RST(a_ptr_consistent, clk, rst_n, OUT_AW'(wr_ptr_r - rd_ptr_r) == cnt_r[OUT_AW-1:0])
  `ASSERT_RST(a_push_shows, clk, rst_n, push |=> out_valid)

endmodule

@@ src/dual_resolution_particle_binner_core.sv @@
// Two-resolution particle histogram. Each beat is a particle, a frame-end tick or a bin
// read, and every beat gives exactly one result beat, in order. One beat is accepted per
// cycle while in_stall is low; its result passes s1_r, s2_r and s3_r into an eight-entry
// result queue. The rate is set by the read-modify-write of the bin memories (one coarse
// and one fine RAM, each with a registered read and a write-back forwarded to the next
// beat). The queue lets input continue while out_stall is high; in_stall rises when
// eight beats are accepted but not yet delivered. After reset both bin RAMs are cleared,
// one entry per cycle, with in_stall high; configuration writes are taken then.
`include "assert_macros.svh"

module dual_resolution_particle_binner_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [drpb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [drpb_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             in_kind,
  input  logic signed [drpb_pkg::POS_W-1:0]      in_x_pos,
  input  logic signed [drpb_pkg::POS_W-1:0]      in_z_pos,
  input  logic signed [drpb_pkg::STRESS_W-1:0]   in_stress_xx,
  input  logic signed [drpb_pkg::STRESS_W-1:0]   in_stress_yy,
  input  logic signed [drpb_pkg::STRESS_W-1:0]   in_stress_zz,
  input  logic [drpb_pkg::RIDX_W-1:0]            in_read_index,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_accepted,
  output logic [drpb_pkg::CAW-1:0]               out_coarse_hit,
  output logic [drpb_pkg::FAW-1:0]               out_fine_hit,
  output logic [drpb_pkg::CNT_W-1:0]             out_bin_count,
  output logic signed [drpb_pkg::SUM_W-1:0]      out_bin_stress,
  output logic [drpb_pkg::FRAME_W-1:0]           out_frames_averaged
);
  import drpb_pkg::*;

  cfg_t               cfg_r;
  front_t             s1_r;
  mult_t              s2_r, s2_nxt;
  rmw_t               s3_r, s3_nxt;
  logic               in_fire, out_pop;
  logic [OUT_CW-1:0]  credit_r, credit_nxt;
  logic               clr_active_r;
  logic [BANK_AW-1:0] clr_addr_r;

  logic [CAW:0]       n_c;
  logic [FAW:0]       n_f;
  logic [CAW-1:0]     last_c;
  logic [FAW-1:0]     last_f;
  logic [RAW_W-1:0]   raw_c, raw_f;
  logic [CAW-1:0]     bin_c;
  logic [FAW-1:0]     bin_f;

  entry_t             rdata_c, rdata_f, cur_c, cur_f, acc_wdata_c, acc_wdata_f;
  logic               acc_we_c, acc_we_f;
  logic               ram_we_c, ram_we_f;
  logic [CAW-1:0]     waddr_c;
  logic [FAW-1:0]     waddr_f;
  entry_t             wdata_c, wdata_f;
  result_t            res, head;

  assign in_fire  = in_valid && !in_stall;
  assign in_stall = clr_active_r || (credit_r == OUT_CW'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_low       <= '0;
      cfg_r.x_high      <= '0;
      cfg_r.z_high      <= '0;
      cfg_r.coarse_inv  <= INV_W'(131072);
      cfg_r.fine_inv    <= INV_W'(262144);
      cfg_r.coarse_used <= CU_W'(2048);
      cfg_r.fine_used   <= FU_W'(4096);
      cfg_r.warmup      <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_X_LOW:       cfg_r.x_low       <= cfg_wdata;
        CFG_X_HIGH:      cfg_r.x_high      <= cfg_wdata;
        CFG_Z_HIGH:      cfg_r.z_high      <= cfg_wdata[ZH_W-1:0];
        CFG_COARSE_INV:  cfg_r.coarse_inv  <= cfg_wdata[INV_W-1:0];
        CFG_FINE_INV:    cfg_r.fine_inv    <= cfg_wdata[INV_W-1:0];
        CFG_COARSE_USED: cfg_r.coarse_used <= cfg_wdata[CU_W-1:0];
        CFG_FINE_USED:   cfg_r.fine_used   <= cfg_wdata[FU_W-1:0];
        CFG_WARMUP:      cfg_r.warmup      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  drpb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_fire       (in_fire),
    .in_kind       (in_kind),
    .in_x_pos      (in_x_pos),
    .in_z_pos      (in_z_pos),
    .in_stress_xx  (in_stress_xx),
    .in_stress_yy  (in_stress_yy),
    .in_stress_zz  (in_stress_zz),
    .in_read_index (in_read_index),
    .s1_r          (s1_r)
  );

  // offset times bins per angstrom
  always_comb begin
    s2_nxt.valid      = s1_r.valid;
    s2_nxt.kind       = s1_r.kind;
    s2_nxt.bin        = s1_r.bin;
    s2_nxt.prod_c     = PROD_W'(s1_r.offset) * PROD_W'(cfg_r.coarse_inv);
    s2_nxt.prod_f     = PROD_W'(s1_r.offset) * PROD_W'(cfg_r.fine_inv);
    s2_nxt.trace      = s1_r.trace;
    s2_nxt.read_index = s1_r.read_index;
    s2_nxt.frames     = s1_r.frames;
  end

  // last bin in use, zero acts as one and oversize as the depth
  always_comb begin
    if (cfg_r.coarse_used == '0) begin
      n_c = (CAW+1)'(1);
    end else if (32'(cfg_r.coarse_used) > 32'(COARSE_DEPTH)) begin
      n_c = (CAW+1)'(COARSE_DEPTH);
    end else begin
      n_c = (CAW+1)'(cfg_r.coarse_used);
    end
    if (cfg_r.fine_used == '0) begin
      n_f = (FAW+1)'(1);
    end else if (32'(cfg_r.fine_used) > 32'(FINE_DEPTH)) begin
      n_f = (FAW+1)'(FINE_DEPTH);
    end else begin
      n_f = (FAW+1)'(cfg_r.fine_used);
    end
  end

  assign last_c = CAW'(n_c - 1'b1);
  assign last_f = FAW'(n_f - 1'b1);
  assign raw_c  = s2_r.prod_c[PROD_W-1:FRAC_W];
  assign raw_f  = s2_r.prod_f[PROD_W-1:FRAC_W];
  assign bin_c  = (raw_c > RAW_W'(last_c)) ? last_c : raw_c[CAW-1:0];
  assign bin_f  = (raw_f > RAW_W'(last_f)) ? last_f : raw_f[FAW-1:0];

  always_comb begin
    s3_nxt.valid  = s2_r.valid;
    s3_nxt.kind   = s2_r.kind;
    s3_nxt.bin    = s2_r.bin;
    s3_nxt.c_ok   = 32'(s2_r.read_index) < 32'(COARSE_DEPTH);
    s3_nxt.f_ok   = 32'(s2_r.read_index) < 32'(FINE_DEPTH);
    s3_nxt.trace  = s2_r.trace;
    s3_nxt.frames = s2_r.frames;
    if (s2_r.kind == KIND_PARTICLE) begin
      s3_nxt.addr_c = bin_c;
      s3_nxt.addr_f = bin_f;
    end else begin
      s3_nxt.addr_c = s2_r.read_index[CAW-1:0];
      s3_nxt.addr_f = s2_r.read_index[FAW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r <= '0;
      s3_r <= '0;
    end else begin
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == BANK_AW'(CLR_DEPTH - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  assign ram_we_c = clr_active_r || acc_we_c;
  assign ram_we_f = clr_active_r || acc_we_f;
  assign waddr_c  = clr_active_r ? clr_addr_r[CAW-1:0] : s3_r.addr_c;
  assign waddr_f  = clr_active_r ? clr_addr_r[FAW-1:0] : s3_r.addr_f;
  assign wdata_c  = clr_active_r ? '0 : acc_wdata_c;
  assign wdata_f  = clr_active_r ? '0 : acc_wdata_f;

  drpb_ram #(
    .DEPTH (COARSE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram_c (
    .clk   (clk),
    .we    (ram_we_c),
    .waddr (waddr_c),
    .wdata (wdata_c),
    .raddr (s3_nxt.addr_c),
    .rdata (rdata_c)
  );

  drpb_ram #(
    .DEPTH (FINE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram_f (
    .clk   (clk),
    .we    (ram_we_f),
    .waddr (waddr_f),
    .wdata (wdata_f),
    .raddr (s3_nxt.addr_f),
    .rdata (rdata_f)
  );

  drpb_accum u_acc_c (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (s3_r.valid && s3_r.bin),
    .addr  (BANK_AW'(s3_r.addr_c)),
    .trace (s3_r.trace),
    .rdata (rdata_c),
    .cur   (cur_c),
    .we    (acc_we_c),
    .wdata (acc_wdata_c)
  );

  drpb_accum u_acc_f (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (s3_r.valid && s3_r.bin),
    .addr  (BANK_AW'(s3_r.addr_f)),
    .trace (s3_r.trace),
    .rdata (rdata_f),
    .cur   (cur_f),
    .we    (acc_we_f),
    .wdata (acc_wdata_f)
  );

  always_comb begin
    res.accepted        = s3_r.bin;
    res.coarse_hit      = s3_r.bin ? s3_r.addr_c : '0;
    res.fine_hit        = s3_r.bin ? s3_r.addr_f : '0;
    res.bin_count       = '0;
    res.bin_stress      = '0;
    res.frames_averaged = s3_r.frames;
    if (s3_r.kind == KIND_RD_COARSE && s3_r.c_ok) begin
      res.bin_count  = cur_c.cnt;
      res.bin_stress = cur_c.sum;
    end else if (s3_r.kind == KIND_RD_FINE && s3_r.f_ok) begin
      res.bin_count  = cur_f.cnt;
      res.bin_stress = cur_f.sum;
    end
  end

  drpb_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s3_r.valid),
    .push_data (res),
    .pop       (out_pop),
    .out_valid (out_valid),
    .head      (head)
  );

  assign out_pop             = out_valid && !out_stall;
  assign out_accepted        = head.accepted;
  assign out_coarse_hit      = head.coarse_hit;
  assign out_fine_hit        = head.fine_hit;
  assign out_bin_count       = head.bin_count;
  assign out_bin_stress      = head.bin_stress;
  assign out_frames_averaged = head.frames_averaged;

  // beats accepted and not yet delivered
  always_comb begin
    credit_nxt = credit_r;
    if (in_fire && !out_pop) begin
      credit_nxt = credit_r + 1'b1;
    end else if (out_pop && !in_fire) begin
      credit_nxt = credit_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_nxt;
    end
  end

  `ASSERT_RST(a_clear_no_beats, clk, rst_n, clr_active_r |-> !s2_r.valid && !s3_r.valid)
  `ASSERT_RST(a_credit_bound, clk, rst_n, credit_r <= OUT_CW'(OUT_DEPTH))
  `ASSERT_RST(a_result_queued, clk, rst_n, s3_r.valid |=> out_valid)

endmodule

@@ test/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import drpb_pkg::*;

  localparam int LIMIT = 600000;
  localparam int TAIL_CYCLES = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int S_MAX = 32'sh7FFF_FFFF;
  localparam int S_MIN = -2147483647 - 1;
  localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    kind_t                      kind;
    logic signed [POS_W-1:0]    x_pos;
    logic signed [POS_W-1:0]    z_pos;
    logic signed [STRESS_W-1:0] stress_xx;
    logic signed [STRESS_W-1:0] stress_yy;
    logic signed [STRESS_W-1:0] stress_zz;
    logic [RIDX_W-1:0]          read_index;
  } particle_beat_t;

  class histogram_tracker;
    bit signed [POS_W-1:0] x_low;
    bit signed [POS_W-1:0] x_high;
    bit [ZH_W-1:0]         z_high;
    bit [INV_W-1:0]        coarse_inv = 24'd131072;
    bit [INV_W-1:0]        fine_inv = 24'd262144;
    bit [CU_W-1:0]         coarse_used = 12'd2048;
    bit [FU_W-1:0]         fine_used = 13'd4096;
    bit [FRAME_W-1:0]      warmup;

    bit [CNT_W-1:0] coarse_cnt [COARSE_DEPTH];
    longint         coarse_sum [COARSE_DEPTH];
    bit [CNT_W-1:0] fine_cnt [FINE_DEPTH];
    longint         fine_sum [FINE_DEPTH];
    bit [FRAME_W-1:0] frame_no;
    bit [FRAME_W-1:0] frames_kept;

    result_t due_results [$];
    int errors;

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_X_LOW:       x_low = v;
        CFG_X_HIGH:      x_high = v;
        CFG_Z_HIGH:      z_high = v[ZH_W-1:0];
        CFG_COARSE_INV:  coarse_inv = v[INV_W-1:0];
        CFG_FINE_INV:    fine_inv = v[INV_W-1:0];
        CFG_COARSE_USED: coarse_used = v[CU_W-1:0];
        CFG_FINE_USED:   fine_used = v[FU_W-1:0];
        CFG_WARMUP:      warmup = v;
        default: ;
      endcase
    endfunction

    function longint unsigned bin_of(longint unsigned offset, longint unsigned inv,
                                     longint unsigned used, longint unsigned depth);
      longint unsigned idx;
      longint unsigned n;
      idx = (offset * inv) >> FRAC_W;
      n = used;
      if (n == 0) n = 1;
      if (n > depth) n = depth;
      if (idx > n - 1) idx = n - 1;
      return idx;
    endfunction

    function longint sat_add(longint s, longint t);
      longint r;
      r = s + t;
      if (r > SUM_MAX) r = SUM_MAX;
      if (r < SUM_MIN) r = SUM_MIN;
      return r;
    endfunction

    function void note_sample(particle_beat_t b);
      result_t r;
      longint x, z, lo, hi, trace;
      longint unsigned cb, fb;
      r = '0;
      case (b.kind)
        KIND_PARTICLE: begin
          x = longint'(b.x_pos);
          z = longint'(b.z_pos);
          lo = longint'(x_low);
          hi = longint'(x_high);
          if (frame_no >= warmup && x >= lo && x <= hi && z >= 0 && z <= longint'(z_high)) begin
            trace = longint'($signed(b.stress_xx)) + longint'($signed(b.stress_yy))
                    + longint'($signed(b.stress_zz));
            cb = bin_of(x - lo, coarse_inv, coarse_used, COARSE_DEPTH);
            fb = bin_of(x - lo, fine_inv, fine_used, FINE_DEPTH);
            if (coarse_cnt[cb] != COUNT_MAX) coarse_cnt[cb] += 1;
            coarse_sum[cb] = sat_add(coarse_sum[cb], trace);
            if (fine_cnt[fb] != COUNT_MAX) fine_cnt[fb] += 1;
            fine_sum[fb] = sat_add(fine_sum[fb], trace);
            r.accepted = 1'b1;
            r.coarse_hit = cb[CAW-1:0];
            r.fine_hit = fb[FAW-1:0];
          end
        end
        KIND_FRAME: begin
          if (frame_no >= warmup && frames_kept != COUNT_MAX) frames_kept += 1;
          if (frame_no != COUNT_MAX) frame_no += 1;
        end
        KIND_RD_COARSE: begin
          if (b.read_index < COARSE_DEPTH) begin
            r.bin_count = coarse_cnt[b.read_index];
            r.bin_stress = coarse_sum[b.read_index][SUM_W-1:0];
          end
        end
        KIND_RD_FINE: begin
          if (b.read_index < FINE_DEPTH) begin
            r.bin_count = fine_cnt[b.read_index];
            r.bin_stress = fine_sum[b.read_index][SUM_W-1:0];
          end
        end
        default: ;
      endcase
      r.frames_averaged = frames_kept;
      due_results.push_back(r);
    endfunction

    function void report_field(string field, logic [63:0] want, logic [63:0] got);
      errors++;
      $error("%s: expected 'h%0h, got 'h%0h", field, want, got);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $error("result beat with no expected result waiting");
        return;
      end
      want = due_results.pop_front();
      if (got.accepted !== want.accepted)
        report_field("accepted", 64'(want.accepted), 64'(got.accepted));
      if (got.coarse_hit !== want.coarse_hit)
        report_field("coarse_hit", 64'(want.coarse_hit), 64'(got.coarse_hit));
      if (got.fine_hit !== want.fine_hit)
        report_field("fine_hit", 64'(want.fine_hit), 64'(got.fine_hit));
      if (got.bin_count !== want.bin_count)
        report_field("bin_count", 64'(want.bin_count), 64'(got.bin_count));
      if (got.bin_stress !== want.bin_stress)
        report_field("bin_stress", 64'(want.bin_stress), 64'(got.bin_stress));
      if (got.frames_averaged !== want.frames_averaged)
        report_field("frames_averaged", 64'(want.frames_averaged),
                     64'(got.frames_averaged));
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_X_LOW;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  particle_beat_t offered = '0;

  logic in_stall;
  logic out_valid;
  logic out_accepted;
  logic [CAW-1:0] out_coarse_hit;
  logic [FAW-1:0] out_fine_hit;
  logic [CNT_W-1:0] out_bin_count;
  logic signed [SUM_W-1:0] out_bin_stress;
  logic [FRAME_W-1:0] out_frames_averaged;

  histogram_tracker sb = new();
  int unsigned n_taken = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;

  dual_resolution_particle_binner_core uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (offered.kind),
    .in_x_pos            (offered.x_pos),
    .in_z_pos            (offered.z_pos),
    .in_stress_xx        (offered.stress_xx),
    .in_stress_yy        (offered.stress_yy),
    .in_stress_zz        (offered.stress_zz),
    .in_read_index       (offered.read_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_accepted        (out_accepted),
    .out_coarse_hit      (out_coarse_hit),
    .out_fine_hit        (out_fine_hit),
    .out_bin_count       (out_bin_count),
    .out_bin_stress      (out_bin_stress),
    .out_frames_averaged (out_frames_averaged)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_result({out_accepted, out_coarse_hit, out_fine_hit, out_bin_count,
                         out_bin_stress, out_frames_averaged});
      end
      if (in_valid && !in_stall) begin
        sb.note_sample(offered);
        n_taken++;
      end
    end
  end

  // long hold-off on request, random stalls otherwise
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      hold_seen <= hold_req;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  function automatic longint unsigned rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic particle_beat_t make_sample(kind_t k, int x, int z, int sx, int sy,
                                                 int sz, int idx);
    particle_beat_t s;
    s.kind = k;
    s.x_pos = x;
    s.z_pos = z;
    s.stress_xx = sx;
    s.stress_yy = sy;
    s.stress_zz = sz;
    s.read_index = RIDX_W'(idx);
    return s;
  endfunction

  function automatic particle_beat_t random_sample();
    particle_beat_t s;
    int unsigned roll;
    longint lo, hi;
    longint unsigned span, used;
    s = make_sample(KIND_PARTICLE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      s.kind = KIND_FRAME;
    end else if (roll < 40) begin
      s.kind = (roll < 24) ? KIND_RD_COARSE : KIND_RD_FINE;
      used = (roll < 24) ? 64'(sb.coarse_used) : 64'(sb.fine_used);
      if ($urandom_range(0, 1)) begin
        s.read_index = RIDX_W'($urandom_range(0, (used >= 4095) ? 4095 : used + 1));
      end
    end else begin
      lo = longint'(sb.x_low);
      hi = longint'(sb.x_high);
      if ($urandom_range(0, 3) != 0 && hi >= lo) begin
        span = hi - lo;
        case ($urandom_range(0, 9))
          0: s.x_pos = POS_W'(lo);
          1: s.x_pos = POS_W'(hi);
          default: s.x_pos = POS_W'(lo + rand64() % (span + 1));
        endcase
        case ($urandom_range(0, 9))
          0: s.z_pos = 0;
          1: s.z_pos = POS_W'(sb.z_high);
          default: s.z_pos = POS_W'(rand64() % (longint'(sb.z_high) + 1));
        endcase
      end
      case ($urandom_range(0, 9))
        0: begin
          s.stress_xx = S_MAX;
          s.stress_yy = S_MAX;
          s.stress_zz = S_MAX;
        end
        1: begin
          s.stress_xx = S_MIN;
          s.stress_yy = S_MIN;
          s.stress_zz = S_MIN;
        end
        default: ;
      endcase
    end
    return s;
  endfunction

  task automatic send_beat(input particle_beat_t s);
    int unsigned seen;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    offered <= s;
    in_valid <= 1'b1;
    seen = n_taken;
    do @(negedge clk); while (n_taken == seen);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    sb.write_reg(idx, v);
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [31:0] xl, xh, zh, ci, fi, cu, fu, wf);
    put_reg(CFG_X_LOW, xl);
    put_reg(CFG_X_HIGH, xh);
    put_reg(CFG_Z_HIGH, zh);
    put_reg(CFG_COARSE_INV, ci);
    put_reg(CFG_FINE_INV, fi);
    put_reg(CFG_COARSE_USED, cu);
    put_reg(CFG_FINE_USED, fu);
    put_reg(CFG_WARMUP, wf);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_beat(random_sample());
    drain();
  endtask

  initial begin
    logic [31:0] base;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // window of +-100 A, 1 and 2 bins per A, two warm-up frames
    load_settings(-25600, 25600, 5120, 32'h10000, 32'h20000, 200, 400, 2);
    send_beat(make_sample(KIND_PARTICLE, 0, 0, 1, 1, 1, 0));
    repeat (3) send_beat(make_sample(KIND_FRAME, 0, 0, 0, 0, 0, 0));
    send_beat(make_sample(KIND_PARTICLE, -25600, 0, S_MAX, S_MAX, S_MAX, 0));
    send_beat(make_sample(KIND_PARTICLE, 25600, 5120, S_MIN, S_MIN, S_MIN, 0));
    send_beat(make_sample(KIND_PARTICLE, -25601, 10, 5, 5, 5, 0));
    send_beat(make_sample(KIND_PARTICLE, 25601, 10, 5, 5, 5, 0));
    send_beat(make_sample(KIND_PARTICLE, 0, -1, 5, 5, 5, 0));
    send_beat(make_sample(KIND_PARTICLE, 0, 5121, 5, 5, 5, 0));
    send_beat(make_sample(KIND_PARTICLE, S_MIN, 0, 5, 5, 5, 0));
    send_beat(make_sample(KIND_PARTICLE, S_MAX, 0, 5, 5, 5, 0));
    send_beat(make_sample(KIND_PARTICLE, 1234, 77, -5, 9, 100, 0));
    send_beat(make_sample(KIND_RD_COARSE, 0, 0, 0, 0, 0, 0));
    send_beat(make_sample(KIND_RD_COARSE, 0, 0, 0, 0, 0, 199));
    send_beat(make_sample(KIND_RD_COARSE, 0, 0, 0, 0, 0, 2047));
    send_beat(make_sample(KIND_RD_COARSE, 0, 0, 0, 0, 0, 2048));
    send_beat(make_sample(KIND_RD_COARSE, 0, 0, 0, 0, 0, 4095));
    send_beat(make_sample(KIND_RD_COARSE, 0, 0, 0, 0, 0, 500));
    send_beat(make_sample(KIND_RD_FINE, 0, 0, 0, 0, 0, 0));
    send_beat(make_sample(KIND_RD_FINE, 0, 0, 0, 0, 0, 399));
    send_beat(make_sample(KIND_RD_FINE, 0, 0, 0, 0, 0, 1000));
    send_beat(make_sample(KIND_RD_FINE, 0, 0, 0, 0, 0, 4095));
    drain();

    load_settings(-25600, 25600, 5120, 32'h10000, 32'h20000,
                  $urandom_range(1, 64), $urandom_range(1, 128), 0);
    run_random(200, 0, 0);

    base = $urandom;
    load_settings(base, base + $urandom_range(0, 1 << 30), $urandom, $urandom, $urandom,
                  $urandom_range(1, 2048), $urandom_range(1, 4096), sb.frame_no + 10);
    run_random(300, 65, 0);

    // full range window, most bins per A, bins used beyond depth
    load_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h00FF_FFFF,
                  32'hFFF, 32'h1FFF, 0);
    run_random(300, 0, 65);

    // zero inverse width and zero bins used
    load_settings(-1000, 100000, 1000, 0, 0, 0, 0, 0);
    run_random(250, 9, 9);

    load_settings(0, 32'h0010_0000, 32'h7FFF_FFFF, 32'h10000, 32'hFFFFFF, 0, 4097, 0);
    run_random(200, 0, 0);

    // inverted window, warm-up never ends
    load_settings(1000, -1000, 5000, 32'h10000, 32'h10000, 16, 16, 32'hFFFF_FFFF);
    run_random(150, 65, 0);

    // receiver holds off while the sender keeps offering
    load_settings(-2560, 2560, 2560, 32'h40000, 32'h80000, 32, 64, 0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_req = hold_req + 1;
    @(negedge clk);
    repeat (80) send_beat(random_sample());
    drain();
    run_random(200, 9, 9);

    // pile large positive stress into bin 0 and large negative stress into bin 1
    load_settings(0, 4096, 256, 32'hFFFFFF, 32'hFFFFFF, 2, 2, 0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 20; i++) begin
      send_beat(make_sample(KIND_PARTICLE, 0, 0, S_MAX, S_MAX, S_MAX, 0));
      if (i % 5 == 0) send_beat(make_sample(KIND_RD_COARSE, 0, 0, 0, 0, 0, 0));
    end
    for (int i = 0; i < 20; i++) begin
      send_beat(make_sample(KIND_PARTICLE, 256, 0, S_MIN, S_MIN, S_MIN, 0));
      if (i % 5 == 0) send_beat(make_sample(KIND_RD_FINE, 0, 0, 0, 0, 0, 1));
    end
    send_beat(make_sample(KIND_RD_COARSE, 0, 0, 0, 0, 0, 0));
    send_beat(make_sample(KIND_RD_COARSE, 0, 0, 0, 0, 0, 1));
    send_beat(make_sample(KIND_RD_FINE, 0, 0, 0, 0, 0, 0));
    send_beat(make_sample(KIND_RD_FINE, 0, 0, 0, 0, 0, 1));
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
